// File: hw/rtl/smd_pkg.sv
package smd_pkg;

  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIX
  } state_t;

endpackage

// File: hw/rtl/smd_if.sv
interface smd_in_if #(
  parameter int WORD_BITS = smd_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] multiplicand;
  logic signed [WORD_BITS-1:0] multiplier;
  logic signed [WORD_BITS-1:0] divisor;

  modport source (output valid, multiplicand, multiplier, divisor, input ready);
  modport sink   (input valid, multiplicand, multiplier, divisor, output ready);
endinterface

interface smd_out_if #(
  parameter int WORD_BITS = smd_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] quotient;
  logic signed [WORD_BITS-1:0] remainder;

  modport source (output valid, quotient, remainder, input ready);
  modport sink   (input valid, quotient, remainder, output ready);
endinterface

// File: hw/rtl/signed_multiply_divide.sv
// An accepted item passes the divide, multiply and sign-fix states into the output register;
//   the sign fix waits while the previous result sits unaccepted in the output register.
// Items are taken one at a time: each runs the divide steps, the multiply steps and the sign
//   fix, and the sequencer returns to idle before it takes the next item.
// A finished result waits in the output register while the next item is taken in.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle and drops out valid.
module signed_multiply_divide #(
  parameter int WORD_BITS = smd_pkg::WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  smd_in_if.sink     in_item,
  smd_out_if.source  out_item
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_BITS - 1);

  smd_pkg::state_t state_r, state_nxt;

  // Working registers
  logic [WORD_BITS-1:0] ua_r, ua_nxt;   // |a|, shifted right one bit per multiply cycle
  logic [WORD_BITS-1:0] qp_r, qp_nxt;   // dividend/quotient shift reg, then partial quotient
  logic [WORD_BITS-1:0] rp_r, rp_nxt;   // partial remainder, always below |c|
  logic [WORD_BITS-1:0] uc_r, uc_nxt;   // |c|, zero replaced by one
  logic [WORD_BITS-1:0] q_r, q_nxt;     // running quotient, wraps
  logic [WORD_BITS-1:0] r_r, r_nxt;     // running remainder
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 qneg_r, qneg_nxt;
  logic                 rneg_r, rneg_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_q_r, out_q_nxt;
  logic [WORD_BITS-1:0] out_r_r, out_r_nxt;

  // Datapath terms
  logic [WORD_BITS-1:0] a_u, b_u, c_u;
  logic [WORD_BITS-1:0] a_mag, b_mag, c_mag;
  logic [WORD_BITS:0]   div_trial;
  logic                 div_ge;
  logic [WORD_BITS:0]   r_sum;
  logic                 r_ge;
  logic [WORD_BITS:0]   rp_dbl;
  logic                 rp_ge;
  logic                 in_fire;
  logic                 out_free;

  assign a_u = in_item.multiplicand;
  assign b_u = in_item.multiplier;
  assign c_u = in_item.divisor;

  // Magnitudes as unsigned words; the most negative value maps to 2^(W-1)
  assign a_mag = a_u[WORD_BITS-1] ? (~a_u + 1'b1) : a_u;
  assign b_mag = b_u[WORD_BITS-1] ? (~b_u + 1'b1) : b_u;
  assign c_mag = (c_u == '0) ? WORD_BITS'(1) :
                 (c_u[WORD_BITS-1] ? (~c_u + 1'b1) : c_u);

  // Restoring divide step: one dividend bit enters the remainder per cycle
  assign div_trial = {rp_r, qp_r[WORD_BITS-1]};
  assign div_ge    = (div_trial >= {1'b0, uc_r});

  // Multiply step: add partial terms when the bit of |a| is set
  assign r_sum  = {1'b0, r_r} + {1'b0, rp_r};
  assign r_ge   = (r_sum >= {1'b0, uc_r});
  // Double the partial term, reducing the remainder part
  assign rp_dbl = {rp_r, 1'b0};
  assign rp_ge  = (rp_dbl >= {1'b0, uc_r});

  assign in_fire  = in_item.valid && in_item.ready;
  assign out_free = !out_valid_r || out_item.ready;

  assign in_item.ready      = (state_r == smd_pkg::ST_IDLE);
  assign out_item.valid     = out_valid_r;
  assign out_item.quotient  = out_q_r;
  assign out_item.remainder = out_r_r;

  always_comb begin
    state_nxt     = state_r;
    ua_nxt        = ua_r;
    qp_nxt        = qp_r;
    rp_nxt        = rp_r;
    uc_nxt        = uc_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    qneg_nxt      = qneg_r;
    rneg_nxt      = rneg_r;
    out_q_nxt     = out_q_r;
    out_r_nxt     = out_r_r;
    out_valid_nxt = out_valid_r && !out_item.ready;

    unique case (state_r)
      smd_pkg::ST_IDLE: begin
        if (in_fire) begin
          ua_nxt    = a_mag;
          qp_nxt    = b_mag;
          rp_nxt    = '0;
          uc_nxt    = c_mag;
          q_nxt     = '0;
          r_nxt     = '0;
          cnt_nxt   = '0;
          rneg_nxt  = a_u[WORD_BITS-1] ^ b_u[WORD_BITS-1];
          qneg_nxt  = a_u[WORD_BITS-1] ^ b_u[WORD_BITS-1] ^ c_u[WORD_BITS-1];
          state_nxt = smd_pkg::ST_DIV;
        end
      end

      smd_pkg::ST_DIV: begin
        // |b| / |c|: quotient bits shift in behind the dividend bits
        rp_nxt  = div_ge ? WORD_BITS'(div_trial - {1'b0, uc_r}) : div_trial[WORD_BITS-1:0];
        qp_nxt  = {qp_r[WORD_BITS-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_BIT) begin
          cnt_nxt   = '0;
          state_nxt = smd_pkg::ST_MUL;
        end
      end

      smd_pkg::ST_MUL: begin
        if (ua_r[0]) begin
          q_nxt = q_r + qp_r + {{(WORD_BITS-1){1'b0}}, r_ge};
          r_nxt = r_ge ? WORD_BITS'(r_sum - {1'b0, uc_r}) : r_sum[WORD_BITS-1:0];
        end
        qp_nxt  = {qp_r[WORD_BITS-2:0], 1'b0} + {{(WORD_BITS-1){1'b0}}, rp_ge};
        rp_nxt  = rp_ge ? WORD_BITS'(rp_dbl - {1'b0, uc_r}) : rp_dbl[WORD_BITS-1:0];
        ua_nxt  = {1'b0, ua_r[WORD_BITS-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_BIT) begin
          cnt_nxt   = '0;
          state_nxt = smd_pkg::ST_FIX;
        end
      end

      smd_pkg::ST_FIX: begin
        // sign fix into the output register once it is free
        if (out_free) begin
          out_q_nxt     = qneg_r ? (~q_r + 1'b1) : q_r;
          out_r_nxt     = rneg_r ? (~r_r + 1'b1) : r_r;
          out_valid_nxt = 1'b1;
          state_nxt     = smd_pkg::ST_IDLE;
        end
      end

      default: state_nxt = smd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ua_r    <= ua_nxt;
    qp_r    <= qp_nxt;
    rp_r    <= rp_nxt;
    uc_r    <= uc_nxt;
    q_r     <= q_nxt;
    r_r     <= r_nxt;
    qneg_r  <= qneg_nxt;
    rneg_r  <= rneg_nxt;
    out_q_r <= out_q_nxt;
    out_r_r <= out_r_nxt;
  end

endmodule
